// File: hdl/lpr_pkg.sv
// lpr_pkg: sizes and shared types for the lru page replacement block
// no dependencies; used by lpr_cell, lpr_sat_counter and lru_page_replacement
package lpr_pkg;

  localparam int unsigned FRAMES    = 4;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RANK_W    = FRAME_W;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned PAGE_IN_W = 16;
  localparam int unsigned IDX_OUT_W = 2;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // search state rippling along the row of frame cells
  typedef struct packed {
    logic       hit;
    frame_idx_t hit_idx;
    rank_t      hit_rank;
    logic       empty;
    frame_idx_t empty_idx;
    rank_t      max_rank;
    frame_idx_t max_idx;
  } lpr_chain_t;

  // update broadcast to every cell
  typedef struct packed {
    logic       en;
    logic       fill;
    logic       was_valid;
    frame_idx_t sel;
    rank_t      old_rank;
    page_t      page;
  } lpr_upd_t;

endpackage

// File: hdl/lpr_cell.sv
// lpr_cell: one page frame (page, valid bit, recency rank) with its chain stage
// depends on lpr_pkg
module lpr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpr_pkg::frame_idx_t cell_idx_i,
  input  lpr_pkg::lpr_upd_t   upd_i,
  input  lpr_pkg::lpr_chain_t chain_i,
  output lpr_pkg::lpr_chain_t chain_o
);
  import lpr_pkg::*;

  page_t page_q, page_d;
  logic  valid_q, valid_d;
  rank_t rank_q, rank_d;
  logic  match;

  assign match = valid_q && (page_q == upd_i.page);

  always_comb begin
    chain_o = chain_i;
    if (!chain_i.hit && match) begin
      chain_o.hit      = 1'b1;
      chain_o.hit_idx  = cell_idx_i;
      chain_o.hit_rank = rank_q;
    end
    if (!chain_i.empty && !valid_q) begin
      chain_o.empty     = 1'b1;
      chain_o.empty_idx = cell_idx_i;
    end
    // strict compare keeps the lowest index on a tie
    if (valid_q && (rank_q > chain_i.max_rank)) begin
      chain_o.max_rank = rank_q;
      chain_o.max_idx  = cell_idx_i;
    end
  end

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.en) begin
      if (upd_i.sel == cell_idx_i) begin
        valid_d = 1'b1;
        rank_d  = '0;
        if (upd_i.fill) begin
          page_d = upd_i.page;
        end
      end else if (valid_q && (!upd_i.was_valid || (rank_q < upd_i.old_rank))) begin
        rank_d = rank_q + rank_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// File: hdl/lpr_sat_counter.sv
// lpr_sat_counter: saturating event counter
// depends on lpr_pkg
module lpr_sat_counter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          inc_i,
  output lpr_pkg::cnt_t count_o
);
  import lpr_pkg::*;

  cnt_t cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (inc_i && (cnt_q != '1)) begin
      cnt_d = cnt_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

// File: hdl/lru_page_replacement.sv
// lru_page_replacement: fully associative lru page frame table, one result per request
// result is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle while results are taken; the search ripples combinationally through the frame cells
// a new request is taken while the previous result is being taken (output register)
// reset: all frames empty, ranks and hit/fault totals cleared; page storage not reset
// depends on lpr_pkg, lpr_cell, lpr_sat_counter
module lru_page_replacement (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lpr_pkg::PAGE_IN_W-1:0]   page_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [lpr_pkg::IDX_OUT_W-1:0]   frame_index_o,
  output lpr_pkg::cnt_t                   hit_total_o,
  output lpr_pkg::cnt_t                   fault_total_o
);
  import lpr_pkg::*;

  // request handshake
  logic accept;
  logic out_valid_q, out_valid_d;
  logic hit_q;
  logic [IDX_OUT_W-1:0] idx_q;

  // page number trimmed or zero-extended to the stored width
  logic [PAGE_BITS+PAGE_IN_W-1:0] page_ext;
  page_t page;

  // chain links: link k feeds cell k, last link is the search result
  lpr_chain_t chain [FRAMES+1];
  lpr_upd_t   upd;

  // decision at the end of the chain
  logic       hit;
  frame_idx_t sel;
  logic [FRAME_W+IDX_OUT_W-1:0] sel_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign page_ext = {{PAGE_BITS{1'b0}}, page_i};
  assign page     = page_ext[PAGE_BITS-1:0];

  // chain seed: nothing found yet, victim search starts at frame 0 rank 0
  assign chain[0] = '0;

  // row of frame cells, each passing the search on to its neighbour
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (frame_idx_t'(g)),
      .upd_i      (upd),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1])
    );
  end

  // pick hit frame, else first empty frame, else least recently used frame
  always_comb begin
    hit = chain[FRAMES].hit;
    upd = '0;
    upd.en   = accept;
    upd.page = page;
    if (hit) begin
      sel            = chain[FRAMES].hit_idx;
      upd.was_valid  = 1'b1;
      upd.old_rank   = chain[FRAMES].hit_rank;
      upd.fill       = 1'b0;
    end else if (chain[FRAMES].empty) begin
      sel            = chain[FRAMES].empty_idx;
      upd.was_valid  = 1'b0;
      upd.old_rank   = '0;
      upd.fill       = 1'b1;
    end else begin
      sel            = chain[FRAMES].max_idx;
      upd.was_valid  = 1'b1;
      upd.old_rank   = chain[FRAMES].max_rank;
      upd.fill       = 1'b1;
    end
    upd.sel = sel;
  end

  // frame number masked to the output width
  assign sel_ext = {{IDX_OUT_W{1'b0}}, sel};

  // running totals; they only move on an accepted request, so they match the held result
  lpr_sat_counter u_hit_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (accept && hit),
    .count_o (hit_total_o)
  );

  lpr_sat_counter u_fault_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (accept && !hit),
    .count_o (fault_total_o)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q <= hit;
      idx_q <= sel_ext[IDX_OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_index_o = idx_q;

endmodule

// File: tb/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
// tb_lru_page_replacement: self-checking bench for the lru page frame table
// depends on lpr_pkg and lru_page_replacement, which in turn needs lpr_cell and lpr_sat_counter
module tb_lru_page_replacement;

  import lpr_pkg::*;

  localparam int unsigned NUM_RANDOM  = 400;
  localparam int unsigned CALM_FROM   = 320;   // no idling from this random request on
  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake before giving up
  localparam int unsigned DRAIN_WAIT  = 4;     // settle after the last result; results are registered

  // one planned request
  typedef struct packed {
    logic [PAGE_IN_W-1:0] page;
    logic                 drain;  // hold off until every result is back
    logic                 calm;   // part of the final stretch with no idling
  } page_req_t;

  // one lookup outcome, as the block should report it
  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    cnt_t                 hit_total;
    cnt_t                 fault_total;
  } lookup_res_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [PAGE_IN_W-1:0] page_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [IDX_OUT_W-1:0] frame_index_o;
  cnt_t                 hit_total_o;
  cnt_t                 fault_total_o;

  lru_page_replacement dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .page_i       (page_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .frame_index_o(frame_index_o),
    .hit_total_o  (hit_total_o),
    .fault_total_o(fault_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // frame table mirror
  // ------------------------------------------------------------------
  page_t frame_pg   [FRAMES];
  logic  frame_used [FRAMES] = '{default: 1'b0};
  rank_t frame_age  [FRAMES] = '{default: '0};
  cnt_t  hits_seen          = '0;
  cnt_t  faults_seen        = '0;

  // looks a page up in the mirror, updates it and returns what the block should say
  function automatic lookup_res_t lookup_page(input logic [PAGE_IN_W-1:0] raw);
    page_t       pg;
    int          f;
    int          j;
    logic        found;
    logic        got_empty;
    logic        was_used;
    rank_t       old_age;
    lookup_res_t res;
    pg        = page_t'(raw);
    f         = 0;
    found     = 1'b0;
    got_empty = 1'b0;
    // an empty frame never matches, whatever its storage holds
    for (j = 0; j < FRAMES; j++) begin
      if (!found && frame_used[j] && frame_pg[j] == pg) begin
        f     = j;
        found = 1'b1;
      end
    end
    if (!found) begin
      // lowest empty frame first
      for (j = 0; j < FRAMES; j++) begin
        if (!got_empty && !frame_used[j]) begin
          f         = j;
          got_empty = 1'b1;
        end
      end
      // else the oldest frame, lowest index on a tie
      if (!got_empty) begin
        f = 0;
        for (j = 1; j < FRAMES; j++) begin
          if (frame_age[j] > frame_age[f]) f = j;
        end
      end
      frame_pg[f] = pg;
    end
    // accessed frame becomes newest; younger frames age by one, all of them on a fill of an empty frame
    was_used = found || !got_empty;
    old_age  = frame_age[f];
    for (j = 0; j < FRAMES; j++) begin
      if (j != f && frame_used[j] && (!was_used || frame_age[j] < old_age))
        frame_age[j] = frame_age[j] + 1'b1;
    end
    frame_age[f]  = '0;
    frame_used[f] = 1'b1;
    // totals stick at all ones
    if (found) begin
      if (hits_seen != '1) hits_seen = hits_seen + 1'b1;
    end else begin
      if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
    end
    res.hit         = found;
    res.frame_index = f[IDX_OUT_W-1:0];
    res.hit_total   = hits_seen;
    res.fault_total = faults_seen;
    return res;
  endfunction

  page_req_t   page_reqs[$];
  lookup_res_t expected_lookups[$];
  lookup_res_t want;
  int          sent_cnt    = 0;
  int          recv_cnt    = 0;
  int          err_cnt     = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  logic        calm_phase  = 1'b0;

  task automatic report(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    err_cnt++;
  endtask

  // ------------------------------------------------------------------
  // request driver: takes the next planned page when the slot is free
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      page_i     <= '0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      // request taken at this edge: predict its result now
      if (in_valid_i) begin
        expected_lookups.push_back(lookup_page(page_i));
        sent_cnt <= sent_cnt + 1;
      end
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (page_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (page_reqs[0].drain && (in_valid_i || sent_cnt != recv_cnt)) begin
        // hold off until the pipeline is empty
        in_valid_i <= 1'b0;
      end else if (!page_reqs[0].calm && $urandom_range(0, 5) == 0) begin
        // random idle burst
        in_valid_i <= 1'b0;
        gap_left   <= $urandom_range(0, 2);
      end else begin
        in_valid_i <= 1'b1;
        page_i     <= page_reqs[0].page;
        calm_phase <= page_reqs[0].calm;
        page_reqs.pop_front();
      end
    end
  end

  // ------------------------------------------------------------------
  // result monitor: checks each result against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_lookups.size() == 0) begin
          report($sformatf("result with no request outstanding (hit %0b frame %0d)",
                           hit_o, frame_index_o));
        end else begin
          want = expected_lookups.pop_front();
          if (hit_o !== want.hit)
            report($sformatf("hit: got %0b want %0b", hit_o, want.hit));
          if (frame_index_o !== want.frame_index)
            report($sformatf("frame_index: got %0d want %0d",
                             frame_index_o, want.frame_index));
          if (hit_total_o !== want.hit_total)
            report($sformatf("hit_total: got %0d want %0d", hit_total_o, want.hit_total));
          if (fault_total_o !== want.fault_total)
            report($sformatf("fault_total: got %0d want %0d",
                             fault_total_o, want.fault_total));
        end
      end
      // receiver back-pressure in short random bursts, none in the final stretch
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // hang detector: too long without any handshake on either side
  // ------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("lru_page_replacement: mismatch");
    $finish;
  end

  // ------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ------------------------------------------------------------------
  initial begin
    logic [PAGE_IN_W-1:0] directed[$];
    logic [PAGE_IN_W-1:0] work_set[8];
    page_req_t            req;
    int                   set_size;
    int                   n;
    int                   k;

    // page 0 first: an empty frame must not match even if its storage holds 0;
    // then fill all four frames, evict the oldest twice, hit the oldest, a middle
    // and the newest frame, and walk single bits and the extremes
    directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hA5A5, 16'h5A5A,
                 16'hFFFF, 16'h1234, 16'hA5A5, 16'hA5A5, 16'h8000, 16'h0001,
                 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h0001,
                 16'h7FFF, 16'h0000};
    set_size = 4;
    foreach (directed[i]) begin
      req.page  = directed[i];
      req.drain = (i == directed.size() - 1);
      req.calm  = 1'b0;
      page_reqs.push_back(req);
    end

    // random part: mostly drawn from a small working set so that hits, fills and
    // evictions all happen; sets of up to four mostly stay resident, larger ones thrash
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n % 50 == 0) begin
        set_size = $urandom_range(3, 7);
        for (k = 0; k < 8; k++) work_set[k] = PAGE_IN_W'($urandom);
      end
      if ($urandom_range(0, 4) == 0)
        req.page = PAGE_IN_W'($urandom);
      else
        req.page = work_set[$urandom_range(0, set_size - 1)];
      req.drain = ($urandom_range(0, 39) == 0);
      req.calm  = (n >= CALM_FROM);
      page_reqs.push_back(req);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests handed over, then all results back, then a short settle
    while (page_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sent_cnt != recv_cnt) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (expected_lookups.size() != 0)
      report($sformatf("%0d results never arrived", expected_lookups.size()));

    if (err_cnt == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule
